[src/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the segment closest points pipeline.
// ----------------------------------------------------------------------------
package scp_pkg;

   // Coordinate format of every point on the ports (signed fixed point).
   localparam int COORD_WIDTH = 32;

   // Digit width of the pipelined multipliers: one digit per stage.
   localparam int MUL_DIG = 16;

   // Reciprocal of the small-value threshold (1e-5).
   localparam int EPS_INV = 100000;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_start_z;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type a_end_z;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_start_z;
      coord_type b_end_x;
      coord_type b_end_y;
      coord_type b_end_z;
   } scp_req_type;

   typedef struct packed {
      coord_type near_a_x;
      coord_type near_a_y;
      coord_type near_a_z;
      coord_type near_b_x;
      coord_type near_b_y;
      coord_type near_b_z;
   } scp_rsp_type;

   // Register stages of scp_mul for a second operand of wb bits.
   function automatic int mul_latency(int wb);
      return (wb + MUL_DIG - 1) / MUL_DIG + 2;
   endfunction

   function automatic int max_int(int x, int y);
      return (x > y) ? x : y;
   endfunction

endpackage

[src/scp_mul.sv]
// ----------------------------------------------------------------------------
// scp_mul
// Pipelined signed multiplier: the magnitude of b is consumed one digit per
// stage, then the sign is applied.
// ----------------------------------------------------------------------------
module scp_mul #(
   parameter int WA = 33,
   parameter int WB = 33
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic signed [WA-1:0]  a,
   input  logic signed [WB-1:0]  b,
   output logic signed [WA+WB-1:0] p
);
   import scp_pkg::*;

   localparam int ND = (WB + MUL_DIG - 1) / MUL_DIG;
   localparam int BW = ND * MUL_DIG;
   localparam int PW = WA + WB;
   localparam int MW = WA + MUL_DIG;

   logic [WA-1:0] ma_ff  [ND];
   logic [BW-1:0] mb_ff  [ND];
   logic [PW-1:0] acc_ff [ND+1];
   logic          neg_ff [ND+1];
   logic signed [PW-1:0] p_ff;
   logic [MW-1:0] pp     [ND];

   always_comb begin
      for (int k = 0; k < ND; k++) begin
         pp[k] = MW'(ma_ff[k]) * MW'(mb_ff[k][MUL_DIG-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ma_ff[0]  <= $unsigned(a[WA-1] ? -a : a);
         mb_ff[0]  <= BW'($unsigned(b[WB-1] ? -b : b));
         acc_ff[0] <= '0;
         neg_ff[0] <= a[WA-1] ^ b[WB-1];
         for (int k = 1; k <= ND; k++) begin
            acc_ff[k] <= acc_ff[k-1] + (PW'(pp[k-1]) << (MUL_DIG * (k - 1)));
            neg_ff[k] <= neg_ff[k-1];
         end
         for (int k = 1; k < ND; k++) begin
            ma_ff[k] <= ma_ff[k-1];
            mb_ff[k] <= mb_ff[k-1] >> MUL_DIG;
         end
         p_ff <= neg_ff[ND] ? -$signed(acc_ff[ND]) : $signed(acc_ff[ND]);
      end
   end

   assign p = p_ff;

endmodule

[src/segment_closest_points.sv]
// ----------------------------------------------------------------------------
// segment_closest_points
// Closest point on each of two 3D segments, exact wide fixed point, with
// near-parallel handling, end clamping and rounded bit-serial placement.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_data (scp_req_type)
//   rsp       out         rsp_valid / rsp_ready   rsp_data (scp_rsp_type)
//
// One transaction is accepted per cycle while req_ready is high; the six
// placement lanes take one bit of the direction per stage.
// Reset clears only the valid bits; the datapath has no reset.
// A stalled result waits in the output register while the pipeline keeps
// filling its empty slots; the pipeline stops only when both are occupied.
//
module segment_closest_points #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scp_pkg::scp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output scp_pkg::scp_rsp_type rsp_data
);
   import scp_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;
   localparam int PW1 = 2 * DW;
   localparam int SW  = PW1 + 2;
   localparam int PW2 = 2 * SW;
   localparam int NW  = max_int(max_int(PW2 + 1, SW + 2 * FRAC_BITS + 2),
                                4 * FRAC_BITS + 2) + 1;
   localparam int RW  = NW + 1;
   localparam int L1  = mul_latency(DW);
   localparam int L2  = mul_latency(SW);
   localparam int IS3 = L1 + 2;
   localparam int IS4 = IS3 + L2 + 1;
   localparam int IL0 = IS4 + 3;
   localparam int T   = IL0 + DW + 3;

   typedef logic signed [DW-1:0] dif_type;
   typedef logic signed [SW-1:0] dot_type;
   typedef logic signed [NW-1:0] wide_type;

   typedef struct packed {
      coord_type [2:0] p0;
      coord_type [2:0] q0;
      dif_type   [2:0] du;
      dif_type   [2:0] dv;
   } side_type;

   typedef struct packed {
      dot_type a, b, c, d, e;
   } dots_type;

   typedef struct packed {
      side_type side;
      dots_type k;
   } mid_type;

   typedef struct packed {
      wide_type f, sn, tn, ca, cb, cc, cd, ce;
      side_type side;
   } s4_type;

   typedef struct packed {
      wide_type sn, sd, tn, td, ca, cb, cd;
      side_type side;
   } s5_type;

   typedef struct packed {
      wide_type sn, sd, tn, td;
      side_type side;
   } s6_type;

   localparam wide_type ONE_V = wide_type'(1) <<< (4 * FRAC_BITS);
   // x * EPS_INV < ONE is the same as x below this limit.
   localparam wide_type LIM = (ONE_V + wide_type'(EPS_INV - 1)) / wide_type'(EPS_INV);

   logic [T-1:0] vld_ff;
   logic         adv;
   logic         rsp_valid_ff, rsp_valid_in;
   scp_rsp_type  rsp_ff, rsp_in;

   assign adv       = !vld_ff[T-1] || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[T-2:0], req_valid};
      end
   end

   // Stage 1: input register. Stage 2: differences.
   scp_req_type     req_ff;
   side_type        s2_ff, s2_in;
   dif_type [2:0]   dw_ff, dw_in;

   always_comb begin
      coord_type ps [3];
      coord_type pe [3];
      coord_type qs [3];
      coord_type qe [3];
      ps = '{req_ff.a_start_x, req_ff.a_start_y, req_ff.a_start_z};
      pe = '{req_ff.a_end_x, req_ff.a_end_y, req_ff.a_end_z};
      qs = '{req_ff.b_start_x, req_ff.b_start_y, req_ff.b_start_z};
      qe = '{req_ff.b_end_x, req_ff.b_end_y, req_ff.b_end_z};
      for (int i = 0; i < 3; i++) begin
         s2_in.p0[i] = ps[i];
         s2_in.q0[i] = qs[i];
         s2_in.du[i] = DW'(pe[i]) - DW'(ps[i]);
         s2_in.dv[i] = DW'(qe[i]) - DW'(qs[i]);
         dw_in[i]    = DW'(ps[i]) - DW'(qs[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req_ff <= req_data;
         s2_ff  <= s2_in;
         dw_ff  <= dw_in;
      end
   end

   // First products: five per axis.
   logic signed [PW1-1:0] p_uu [3];
   logic signed [PW1-1:0] p_uv [3];
   logic signed [PW1-1:0] p_vv [3];
   logic signed [PW1-1:0] p_uw [3];
   logic signed [PW1-1:0] p_vw [3];

   for (genvar i = 0; i < 3; i++) begin : g_axis
      scp_mul #(.WA(DW), .WB(DW)) u_uu (.clock(clock), .enable(adv),
         .a(s2_ff.du[i]), .b(s2_ff.du[i]), .p(p_uu[i]));
      scp_mul #(.WA(DW), .WB(DW)) u_uv (.clock(clock), .enable(adv),
         .a(s2_ff.du[i]), .b(s2_ff.dv[i]), .p(p_uv[i]));
      scp_mul #(.WA(DW), .WB(DW)) u_vv (.clock(clock), .enable(adv),
         .a(s2_ff.dv[i]), .b(s2_ff.dv[i]), .p(p_vv[i]));
      scp_mul #(.WA(DW), .WB(DW)) u_uw (.clock(clock), .enable(adv),
         .a(s2_ff.du[i]), .b(dw_ff[i]), .p(p_uw[i]));
      scp_mul #(.WA(DW), .WB(DW)) u_vw (.clock(clock), .enable(adv),
         .a(s2_ff.dv[i]), .b(dw_ff[i]), .p(p_vw[i]));
   end

   side_type d1_ff [L1];
   side_type s3_ff;
   dots_type k3_ff, k3_in;

   always_comb begin
      k3_in.a = dot_type'(p_uu[0]) + dot_type'(p_uu[1]) + dot_type'(p_uu[2]);
      k3_in.b = dot_type'(p_uv[0]) + dot_type'(p_uv[1]) + dot_type'(p_uv[2]);
      k3_in.c = dot_type'(p_vv[0]) + dot_type'(p_vv[1]) + dot_type'(p_vv[2]);
      k3_in.d = dot_type'(p_uw[0]) + dot_type'(p_uw[1]) + dot_type'(p_uw[2]);
      k3_in.e = dot_type'(p_vw[0]) + dot_type'(p_vw[1]) + dot_type'(p_vw[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff[0] <= s2_ff;
         for (int i = 1; i < L1; i++) begin
            d1_ff[i] <= d1_ff[i-1];
         end
         s3_ff <= d1_ff[L1-1];
         k3_ff <= k3_in;
      end
   end

   // Second products.
   logic signed [PW2-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

   scp_mul #(.WA(SW), .WB(SW)) u_ac (.clock(clock), .enable(adv),
      .a(k3_ff.a), .b(k3_ff.c), .p(p_ac));
   scp_mul #(.WA(SW), .WB(SW)) u_bb (.clock(clock), .enable(adv),
      .a(k3_ff.b), .b(k3_ff.b), .p(p_bb));
   scp_mul #(.WA(SW), .WB(SW)) u_be (.clock(clock), .enable(adv),
      .a(k3_ff.b), .b(k3_ff.e), .p(p_be));
   scp_mul #(.WA(SW), .WB(SW)) u_cd (.clock(clock), .enable(adv),
      .a(k3_ff.c), .b(k3_ff.d), .p(p_cd));
   scp_mul #(.WA(SW), .WB(SW)) u_ae (.clock(clock), .enable(adv),
      .a(k3_ff.a), .b(k3_ff.e), .p(p_ae));
   scp_mul #(.WA(SW), .WB(SW)) u_bd (.clock(clock), .enable(adv),
      .a(k3_ff.b), .b(k3_ff.d), .p(p_bd));

   mid_type d2_ff [L2];
   s4_type  s4_ff, s4_in;

   always_comb begin
      mid_type m;
      m = d2_ff[L2-1];
      s4_in.f    = wide_type'(p_ac) - wide_type'(p_bb);
      s4_in.sn   = wide_type'(p_be) - wide_type'(p_cd);
      s4_in.tn   = wide_type'(p_ae) - wide_type'(p_bd);
      s4_in.ca   = wide_type'(m.k.a) <<< (2 * FRAC_BITS);
      s4_in.cb   = wide_type'(m.k.b) <<< (2 * FRAC_BITS);
      s4_in.cc   = wide_type'(m.k.c) <<< (2 * FRAC_BITS);
      s4_in.cd   = wide_type'(m.k.d) <<< (2 * FRAC_BITS);
      s4_in.ce   = wide_type'(m.k.e) <<< (2 * FRAC_BITS);
      s4_in.side = m.side;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff[0] <= '{side: s3_ff, k: k3_ff};
         for (int i = 1; i < L2; i++) begin
            d2_ff[i] <= d2_ff[i-1];
         end
         s4_ff <= s4_in;
      end
   end

   // Stage 5: near-parallel case and clamping of s.
   s5_type s5_ff, s5_in;

   always_comb begin
      wide_type f, sn0;
      f   = s4_ff.f;
      sn0 = s4_ff.sn;
      s5_in.ca   = s4_ff.ca;
      s5_in.cb   = s4_ff.cb;
      s5_in.cd   = s4_ff.cd;
      s5_in.side = s4_ff.side;
      if (f < LIM) begin
         s5_in.sn = '0;
         s5_in.sd = ONE_V;
         s5_in.tn = s4_ff.ce;
         s5_in.td = s4_ff.cc;
      end else begin
         s5_in.sn = sn0;
         s5_in.sd = f;
         s5_in.tn = s4_ff.tn;
         s5_in.td = f;
         if (sn0 < 0) begin
            s5_in.sn = '0;
            s5_in.tn = s4_ff.ce;
            s5_in.td = s4_ff.cc;
         end else if (sn0 > f) begin
            s5_in.sn = f;
            s5_in.tn = s4_ff.ce + s4_ff.cb;
            s5_in.td = s4_ff.cc;
         end
      end
   end

   // Stage 6: clamping of t, with s recomputed against a.
   s6_type s6_ff, s6_in;

   always_comb begin
      wide_type tn, td, ca, m;
      tn = s5_ff.tn;
      td = s5_ff.td;
      ca = s5_ff.ca;
      m  = (tn < 0) ? -s5_ff.cd : s5_ff.cb - s5_ff.cd;
      s6_in.sn   = s5_ff.sn;
      s6_in.sd   = s5_ff.sd;
      s6_in.tn   = tn;
      s6_in.td   = td;
      s6_in.side = s5_ff.side;
      if (tn < 0 || tn > td) begin
         s6_in.tn = (tn < 0) ? '0 : td;
         if (m < 0) begin
            s6_in.sn = '0;
         end else if (m > ca) begin
            s6_in.sn = s5_ff.sd;
         end else begin
            s6_in.sn = m;
            s6_in.sd = ca;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   // Placement lanes: offset = round(|dir| * num / den), one bit of dir per
   // stage. num never exceeds den, so the remainder stays below den.
   coord_type lane_res [6];

   for (genvar g = 0; g < 6; g++) begin : g_lane
      logic [DW-1:0] mag_ff   [DW];
      logic [NW-1:0] num_ff   [DW];
      logic [NW-1:0] den_ff   [DW+1];
      logic [RW-1:0] r_ff     [DW+1];
      logic [DW-1:0] q_ff     [DW+1];
      logic          neg_ff   [DW+1];
      logic          act_ff   [DW+1];
      coord_type     start_ff [DW+1];
      logic [RW-1:0] step_t   [DW];
      logic [RW-1:0] step_r   [DW];
      logic [1:0]    step_d   [DW];
      logic [DW-1:0] qr_ff;
      logic          rneg_ff, ract_ff;
      coord_type     rstart_ff;
      coord_type     res_ff, res_in;
      dif_type       dir;
      coord_type     start;
      wide_type      num, den;

      if (g < 3) begin : g_a
         assign dir   = s6_ff.side.du[g];
         assign start = s6_ff.side.p0[g];
         assign num   = s6_ff.sn;
         assign den   = s6_ff.sd;
      end else begin : g_b
         assign dir   = s6_ff.side.dv[g-3];
         assign start = s6_ff.side.q0[g-3];
         assign num   = s6_ff.tn;
         assign den   = s6_ff.td;
      end

      always_comb begin
         for (int k = 0; k < DW; k++) begin
            step_t[k] = {r_ff[k][RW-2:0], 1'b0}
                        + (mag_ff[k][DW-1] ? RW'(num_ff[k]) : RW'(0));
            if (step_t[k] >= {den_ff[k], 1'b0}) begin
               step_r[k] = step_t[k] - {den_ff[k], 1'b0};
               step_d[k] = 2'd2;
            end else if (step_t[k] >= RW'(den_ff[k])) begin
               step_r[k] = step_t[k] - RW'(den_ff[k]);
               step_d[k] = 2'd1;
            end else begin
               step_r[k] = step_t[k];
               step_d[k] = 2'd0;
            end
         end
      end

      always_comb begin
         logic signed [DW:0]  off;
         logic signed [W+1:0] sum;
         off = $signed({1'b0, qr_ff});
         if (rneg_ff) begin
            off = -off;
         end
         if (!ract_ff) begin
            off = '0;
         end
         sum = (W+2)'(rstart_ff) + (W+2)'(off);
         if (sum[W+1:W-1] == 3'b000 || sum[W+1:W-1] == 3'b111) begin
            res_in = sum[W-1:0];
         end else begin
            res_in = sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            mag_ff[0]   <= $unsigned(dir[DW-1] ? -dir : dir);
            num_ff[0]   <= num;
            den_ff[0]   <= den;
            r_ff[0]     <= '0;
            q_ff[0]     <= '0;
            neg_ff[0]   <= dir[DW-1];
            act_ff[0]   <= !(num < LIM) && (den != '0);
            start_ff[0] <= start;
            for (int k = 1; k <= DW; k++) begin
               r_ff[k]     <= step_r[k-1];
               q_ff[k]     <= {q_ff[k-1][DW-2:0], 1'b0} + DW'(step_d[k-1]);
               den_ff[k]   <= den_ff[k-1];
               neg_ff[k]   <= neg_ff[k-1];
               act_ff[k]   <= act_ff[k-1];
               start_ff[k] <= start_ff[k-1];
            end
            for (int k = 1; k < DW; k++) begin
               mag_ff[k] <= mag_ff[k-1] << 1;
               num_ff[k] <= num_ff[k-1];
            end
            // Round half away from zero on the magnitude.
            qr_ff     <= q_ff[DW]
                         + DW'({r_ff[DW][RW-2:0], 1'b0} >= RW'(den_ff[DW]));
            rneg_ff   <= neg_ff[DW];
            ract_ff   <= act_ff[DW];
            rstart_ff <= start_ff[DW];
            res_ff    <= res_in;
         end
      end

      assign lane_res[g] = res_ff;
   end

   // Output register: takes the last stage whenever it is free or emptied.
   always_comb begin
      rsp_in.near_a_x = lane_res[0];
      rsp_in.near_a_y = lane_res[1];
      rsp_in.near_a_z = lane_res[2];
      rsp_in.near_b_x = lane_res[3];
      rsp_in.near_b_y = lane_res[4];
      rsp_in.near_b_z = lane_res[5];
      rsp_valid_in = (!rsp_valid_ff || rsp_ready) ? vld_ff[T-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vld_ff[T-1] && rsp_valid_ff && !rsp_ready)
      else $error("pipeline stalled without a blocked result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("valid bits moved during a stall");

   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T-1] && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("finished transaction did not reach the output register");

   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !vld_ff[T-1] |=> !rsp_valid_ff)
      else $error("output register repeated a transaction");
`endif

endmodule
